// ----- hdl/edrd_pkg.sv -----
// edrd_pkg: escape codes, result beat type and the decode-to-buffer push bundle
// for the escaped delta run-length decoder; no dependencies
`timescale 1ns / 1ps

package edrd_pkg;

   // escape bytes of the compressed stream and the special sample value
   localparam logic [7:0]  ESC_RUN        = 8'hA5;
   localparam logic [7:0]  ESC_LIT        = 8'h5A;
   localparam logic [7:0]  PEEK_MARK      = 8'h01;
   localparam logic [15:0] SPECIAL_SAMPLE = 16'h0101;

   // one run descriptor as it leaves the block
   typedef struct packed {
      logic [15:0]       first_sample;
      logic signed [7:0] step;
      logic [6:0]        run_count;
      logic              last;
   } result_type;

   // zero, one or two descriptors handed from the decoder to the output buffer
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ----- hdl/edrd_if.sv -----
// edrd_req_if / edrd_rsp_if: valid/ready channels carrying byte and descriptor beats
// no dependencies
`timescale 1ns / 1ps

interface edrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_stream;

   modport source (output valid, output byte_in, output end_of_stream, input ready);
   modport sink (input valid, input byte_in, input end_of_stream, output ready);
endinterface

interface edrd_rsp_if;
   logic              valid;
   logic              ready;
   logic [15:0]       first_sample;
   logic signed [7:0] step;
   logic [6:0]        run_count;
   logic              last;

   modport source (output valid, output first_sample, output step, output run_count,
                   output last, input ready);
   modport sink (input valid, input first_sample, input step, input run_count,
                 input last, output ready);
endinterface

// ----- hdl/edrd_decode.sv -----
// edrd_decode: input byte register, escape state machine and descriptor build
// depends on edrd_pkg and edrd_req_if
`timescale 1ns / 1ps

module edrd_decode (
   input  logic                clock,
   input  logic                reset,
   edrd_req_if.sink            req_ch,
   input  logic [1:0]          free,
   output edrd_pkg::push_type  push
);

   // decode phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_RUN_N = 3'd1;
   localparam logic [2:0] PH_RUN_V = 3'd2;
   localparam logic [2:0] PH_SKIP  = 3'd3;
   localparam logic [2:0] PH_LIT_L = 3'd4;
   localparam logic [2:0] PH_LIT_H = 3'd5;
   localparam logic [2:0] PH_PEEK  = 3'd6;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        byte_ff;
   logic              eos_ff;
   logic [2:0]        phase_ff, phase_in;
   logic [15:0]       base_ff, base_in;
   logic [7:0]        held_ff, held_in;

   logic              consume;
   logic              accept;
   logic [15:0]       delta16;
   logic [6:0]        cnt7;
   logic signed [15:0] cnt_s, step_s, prod;
   logic [15:0]       idle_base;
   logic [15:0]       idle_sum;
   edrd_pkg::result_type r0, r1;
   logic [1:0]        n;

   // input skid register
   assign accept       = req_ch.valid && req_ch.ready;
   assign consume      = in_valid_ff && (n <= free);
   assign req_ch.ready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         byte_ff <= req_ch.byte_in;
         eos_ff  <= req_ch.end_of_stream;
      end
   end

   // run arithmetic: count times signed step
   assign delta16 = {{8{byte_ff[7]}}, byte_ff};
   assign cnt7    = held_ff[6:0] + 7'd1;
   assign cnt_s   = signed'({9'd0, cnt7});
   assign step_s  = signed'(delta16);
   assign prod    = cnt_s * step_s;

   // plain byte path, also used for the byte peeked after 5A A5 01
   assign idle_base = (phase_ff == PH_PEEK) ? {8'd0, edrd_pkg::ESC_RUN} : base_ff;
   assign idle_sum  = idle_base + delta16;

   // next state and descriptors
   always_comb begin
      phase_in = phase_ff;
      base_in  = base_ff;
      held_in  = held_ff;
      n        = 2'd0;
      r0       = '{first_sample: 16'd0, step: 8'sd0, run_count: 7'd1, last: 1'b0};
      r1       = '{first_sample: 16'd0, step: 8'sd0, run_count: 7'd1, last: 1'b0};
      case (phase_ff)
         PH_RUN_N: begin
            held_in  = byte_ff;
            phase_in = PH_RUN_V;
         end
         PH_RUN_V: begin
            if (byte_ff == edrd_pkg::ESC_LIT) begin
               base_in         = {held_ff, edrd_pkg::ESC_LIT};
               r0.first_sample = base_in;
               n               = 2'd1;
               phase_in        = PH_SKIP;
            end else begin
               phase_in = PH_IDLE;
               // empty run when the count wraps to zero or negative
               if (held_ff < 8'd127) begin
                  base_in         = base_ff + prod;
                  r0.first_sample = base_ff + delta16;
                  r0.step         = signed'(byte_ff);
                  r0.run_count    = cnt7;
                  n               = 2'd1;
               end
            end
         end
         PH_SKIP: begin
            phase_in = PH_IDLE;
         end
         PH_LIT_L: begin
            held_in  = byte_ff;
            phase_in = PH_LIT_H;
         end
         PH_LIT_H: begin
            phase_in = PH_IDLE;
            if (held_ff == edrd_pkg::ESC_RUN) begin
               if (byte_ff == edrd_pkg::PEEK_MARK) begin
                  phase_in = PH_PEEK;
               end else begin
                  base_in         = {8'd0, edrd_pkg::ESC_RUN};
                  r0.first_sample = base_in;
                  n               = 2'd1;
               end
            end else begin
               base_in         = {byte_ff, held_ff};
               r0.first_sample = base_in;
               n               = 2'd1;
            end
         end
         PH_PEEK: begin
            phase_in = PH_IDLE;
            if (byte_ff == edrd_pkg::PEEK_MARK) begin
               base_in         = 16'd0;
               r0.first_sample = edrd_pkg::SPECIAL_SAMPLE;
               n               = 2'd1;
            end else begin
               base_in         = {8'd0, edrd_pkg::ESC_RUN};
               r0.first_sample = base_in;
               n               = 2'd1;
               // peeked byte decoded again from idle
               if (byte_ff == edrd_pkg::ESC_RUN) begin
                  phase_in = PH_RUN_N;
               end else if (byte_ff == edrd_pkg::ESC_LIT) begin
                  phase_in = PH_LIT_L;
               end else begin
                  base_in         = idle_sum;
                  r1.first_sample = idle_sum;
                  n               = 2'd2;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (byte_ff == edrd_pkg::ESC_RUN) begin
               phase_in = PH_RUN_N;
            end else if (byte_ff == edrd_pkg::ESC_LIT) begin
               phase_in = PH_LIT_L;
            end else begin
               base_in         = idle_sum;
               r0.first_sample = idle_sum;
               n               = 2'd1;
            end
         end
      endcase
      // end of stream drops any open escape
      if (eos_ff) begin
         phase_in = PH_IDLE;
      end
      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   assign push.count  = consume ? n : 2'd0;
   assign push.first  = r0;
   assign push.second = r1;

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         base_ff  <= 16'd0;
         held_ff  <= 8'd0;
      end else if (consume) begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         held_ff  <= held_in;
      end
   end

`ifndef SYNTH
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_PEEK)
      else $error("decode phase out of range");

   a_eos_idle: assert property (@(posedge clock) disable iff (reset)
      consume && eos_ff |=> phase_ff == PH_IDLE)
      else $error("phase not idle after end of stream");

   a_two_only_peek: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> phase_ff == PH_PEEK)
      else $error("two descriptors outside the peek phase");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(byte_ff) && $stable(eos_ff))
      else $error("stalled input byte lost");
`endif

endmodule

// ----- hdl/edrd_rsp_buf.sv -----
// edrd_rsp_buf: two-entry output register taking up to two descriptors per cycle
// depends on edrd_pkg and edrd_rsp_if
`timescale 1ns / 1ps

module edrd_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  edrd_pkg::push_type push,
   output logic [1:0]         free,
   edrd_rsp_if.source         rsp_ch
);

   logic [1:0]           cnt_ff, cnt_in;
   edrd_pkg::result_type slot_ff [2];
   edrd_pkg::result_type slot_in [2];
   logic                 pop;
   logic [1:0]           base_cnt;

   // pop the head beat, then fill behind what remains
   assign pop      = (cnt_ff != 2'd0) && rsp_ch.ready;
   assign base_cnt = cnt_ff - {1'b0, pop};
   assign free     = 2'd2 - base_cnt;
   assign cnt_in   = base_cnt + push.count;

   always_comb begin
      slot_in[0] = pop ? slot_ff[1] : slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (push.count != 2'd0) begin
         if (base_cnt == 2'd0) begin
            slot_in[0] = push.first;
            slot_in[1] = push.second;
         end else begin
            slot_in[1] = push.first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   // head beat drives the port
   assign rsp_ch.valid        = cnt_ff != 2'd0;
   assign rsp_ch.first_sample = slot_ff[0].first_sample;
   assign rsp_ch.step         = slot_ff[0].step;
   assign rsp_ch.run_count    = slot_ff[0].run_count;
   assign rsp_ch.last         = slot_ff[0].last;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, base_cnt} + {1'b0, push.count}) <= 3'd2)
      else $error("output buffer overflow");

   a_last_single: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd1 |-> push.first.last)
      else $error("single descriptor without last");

   a_last_pair: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.last && push.second.last)
      else $error("descriptor pair with wrong last marks");
`endif

endmodule

// ----- hdl/escaped_delta_rle_decoder_top.sv -----
// Escaped delta run-length decoder, top level.
// Channels: req_ch takes one compressed byte per beat (byte_in, end_of_stream);
// rsp_ch delivers run descriptors (first_sample, step, run_count, last), with
// last set on the final descriptor a byte produces. A byte produces zero, one
// or two descriptors; bytes that only open or continue an escape produce none.
// On its way out, a byte first waits in the input register, and the
// descriptor it yields then waits in the output register before rsp_ch
// offers it; a stall can hold it in either register.
// Throughput: one byte per cycle while each byte yields at most one
// descriptor and rsp_ch.ready stays high; the single output port can hold back
// the bytes after a two-descriptor byte. The escape state never limits the rate.
// Reset (synchronous, active high) returns the decoder to idle with a zero
// base sample and empties both registers; no beat is offered until new bytes.
// Stall: when rsp_ch.ready is low the two-entry output register fills, the
// decoder holds its byte, and req_ch.ready drops once the input register is
// occupied; no descriptor is lost or repeated.
// Depends on edrd_pkg, edrd_if, edrd_decode and edrd_rsp_buf.
`timescale 1ns / 1ps

module escaped_delta_rle_decoder_top (
   input  logic        clock,
   input  logic        reset,
   edrd_req_if.sink    req_ch,
   edrd_rsp_if.source  rsp_ch
);

   edrd_pkg::push_type push;
   logic [1:0]         free;

   // byte register and escape decode
   edrd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .free   (free),
      .push   (push)
   );

   // descriptor output register
   edrd_rsp_buf u_rsp_buf (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .free   (free),
      .rsp_ch (rsp_ch)
   );

endmodule
